// ===== design/b2q_pkg.sv =====
// ----------------------------------------------------------------------------
// b2q_pkg
// Shared constants and types for the basis-to-quaternion converter.
// ----------------------------------------------------------------------------
package b2q_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 14;

	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_X     = 2'd1,
		BR_Y     = 2'd2,
		BR_Z     = 2'd3
	} branch_t;

endpackage

// ===== design/b2q_if.sv =====
// ----------------------------------------------------------------------------
// b2q_in_if / b2q_out_if
// Valid/ready channels: basis matrix request in, quaternion request out.
// ----------------------------------------------------------------------------
interface b2q_in_if import b2q_pkg::*; #(
	parameter int DW = DATA_WIDTH_DEF
);
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] right_x;
	logic signed [DW-1:0] right_y;
	logic signed [DW-1:0] right_z;
	logic signed [DW-1:0] up_x;
	logic signed [DW-1:0] up_y;
	logic signed [DW-1:0] up_z;
	logic signed [DW-1:0] fwd_x;
	logic signed [DW-1:0] fwd_y;
	logic signed [DW-1:0] fwd_z;

	modport source (output valid, right_x, right_y, right_z, up_x, up_y, up_z,
		fwd_x, fwd_y, fwd_z, input ready);
	modport sink (input valid, right_x, right_y, right_z, up_x, up_y, up_z,
		fwd_x, fwd_y, fwd_z, output ready);
endinterface

interface b2q_out_if import b2q_pkg::*; #(
	parameter int DW = DATA_WIDTH_DEF
);
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] quat_x;
	logic signed [DW-1:0] quat_y;
	logic signed [DW-1:0] quat_z;
	logic signed [DW-1:0] quat_w;
	logic [1:0]           branch_case;

	modport source (output valid, quat_x, quat_y, quat_z, quat_w, branch_case,
		input ready);
	modport sink (input valid, quat_x, quat_y, quat_z, quat_w, branch_case,
		output ready);
endinterface

// ===== design/basis_to_quaternion_core.sv =====
// ----------------------------------------------------------------------------
// basis_to_quaternion_core
// Rotation matrix (right/up/forward columns) to unit quaternion, Shepperd.
// ----------------------------------------------------------------------------
// Usage:
//   mat  : sink channel, one matrix request per valid&ready edge.
//   quat : source channel, one quaternion request per accepted matrix,
//          in order; branch_case tells which component came from the root.
// Pipeline: setup stage, square-root stages, divider stages, output register;
//   root width HW = (RW + FRAC_BITS) / 2 and DQ = DATA_WIDTH + 1 +
//   FRAC_BITS quotient bits.
// Throughput: one request per cycle while quat is not stalled. The square root resolves one root bit
//   per stage and the three dividers one quotient bit per stage each.
// Reset: all stage valid bits clear; the pipeline comes up empty and ready.
// Stall: when quat holds a request that is not taken, the whole pipeline
//   freezes and mat.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module basis_to_quaternion_core import b2q_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	b2q_in_if.sink   mat,
	b2q_out_if.source quat
);

	localparam int DW  = DATA_WIDTH;
	localparam int FB  = FRAC_BITS;
	localparam int RW  = ((DW > FB + 1) ? DW : FB + 1) + 3;
	localparam int HW  = (RW - 1 + FB + 1) / 2;
	localparam int XW  = 2 * HW;
	localparam int NW  = DW + 1;
	localparam int DQ  = NW + FB;
	localparam int SW  = (HW > DQ) ? HW : DQ;
	localparam int NST = 1 + HW + DQ;

	localparam logic [SW-1:0] MAXV = SW'((64'(1) << (DW - 1)) - 64'(1));
	localparam logic [DW-1:0] MAXO = DW'((64'(1) << (DW - 1)) - 64'(1));
	localparam logic [DW-1:0] MINO = ~MAXO;
	localparam logic signed [RW-1:0] ONE = RW'(64'(1) << FB);

	typedef struct packed {
		branch_t              sel;
		logic [XW-1:0]        sx;
		logic [HW:0]          srem;
		logic [HW-1:0]        h;
		logic [2:0]           neg;
		logic [2:0]           nzero;
		logic [2:0][HW:0]     drem;
		logic [2:0][DQ-1:0]   dq;
	} pipe_t;

	function automatic logic [DW-1:0] sat_fn(input logic neg, input logic [SW-1:0] mag);
		logic [DW-1:0] res;
		if (neg) begin
			res = (mag > MAXV) ? MINO : DW'(-mag);
		end else begin
			res = (mag > MAXV) ? MAXO : mag[DW-1:0];
		end
		return res;
	endfunction

	pipe_t            pipe_s [NST];
	logic [NST-1:0]   vld_s;
	logic             adv;
	logic             out_vld_q;
	logic [DW-1:0]    qx_q, qy_q, qz_q, qw_q;
	branch_t          br_q;

	assign adv       = !out_vld_q || quat.ready;
	assign mat.ready = adv;

	// stage 1: trace, branch, radicand, numerators
	logic signed [RW-1:0] e00, e11, e22, trace, rad;
	logic signed [NW-1:0] nwd, nbd, ncd, nab, nac, nbc, num [3];
	branch_t              sel_c;
	pipe_t                st0;

	always_comb begin
		e00   = RW'(mat.right_x);
		e11   = RW'(mat.up_y);
		e22   = RW'(mat.fwd_z);
		trace = e00 + e11 + e22;
		nwd   = NW'(mat.up_z) - NW'(mat.fwd_y);
		nbd   = NW'(mat.fwd_x) - NW'(mat.right_z);
		ncd   = NW'(mat.right_y) - NW'(mat.up_x);
		nab   = NW'(mat.up_x) + NW'(mat.right_y);
		nac   = NW'(mat.fwd_x) + NW'(mat.right_z);
		nbc   = NW'(mat.fwd_y) + NW'(mat.up_z);
		if (trace > RW'(0)) begin
			sel_c = BR_TRACE;
			rad   = ONE + trace;
			num[0] = nwd; num[1] = nbd; num[2] = ncd;
		end else if (mat.right_x > mat.up_y && mat.right_x > mat.fwd_z) begin
			sel_c = BR_X;
			rad   = ONE + e00 - e11 - e22;
			num[0] = nwd; num[1] = nab; num[2] = nac;
		end else if (mat.up_y > mat.fwd_z) begin
			sel_c = BR_Y;
			rad   = ONE + e11 - e00 - e22;
			num[0] = nbd; num[1] = nab; num[2] = nbc;
		end else begin
			sel_c = BR_Z;
			rad   = ONE + e22 - e00 - e11;
			num[0] = ncd; num[1] = nac; num[2] = nbc;
		end
		if (rad[RW-1])
			rad = '0;
		st0      = '0;
		st0.sel  = sel_c;
		st0.sx   = XW'(rad[RW-2:0]) << FB;
		for (int i = 0; i < 3; i++) begin
			st0.neg[i]   = num[i][NW-1];
			st0.nzero[i] = (num[i] == '0);
			// magnitude is unsigned: zero-extend
			st0.dq[i]    = DQ'({num[i][NW-1] ? NW'(-num[i]) : NW'(num[i])}) << FB;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= mat.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			pipe_s[0] <= st0;
	end

	// square root, one result bit per stage
	for (genvar k = 0; k < HW; k++) begin : g_sqrt
		pipe_t               nxt;
		logic [HW+2:0]       rem2, trial;
		always_comb begin
			nxt   = pipe_s[k];
			rem2  = {pipe_s[k].srem, pipe_s[k].sx[XW-1:XW-2]};
			trial = (HW+3)'({pipe_s[k].h, 2'b01});
			nxt.sx = pipe_s[k].sx << 2;
			if (rem2 >= trial) begin
				nxt.srem = (HW+1)'(rem2 - trial);
				nxt.h    = {pipe_s[k].h[HW-2:0], 1'b1};
			end else begin
				nxt.srem = (HW+1)'(rem2);
				nxt.h    = {pipe_s[k].h[HW-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv)
				pipe_s[k+1] <= nxt;
		end
	end

	// three restoring dividers by 2h, one quotient bit per stage
	for (genvar j = 0; j < DQ; j++) begin : g_div
		localparam int S = HW + j;
		pipe_t         nxt;
		logic [HW+1:0] t [3];
		logic [HW+1:0] dvs;
		always_comb begin
			nxt = pipe_s[S];
			dvs = (HW+2)'({pipe_s[S].h, 1'b0});
			for (int i = 0; i < 3; i++) begin
				t[i] = {pipe_s[S].drem[i], pipe_s[S].dq[i][DQ-1]};
				if (t[i] >= dvs) begin
					nxt.drem[i] = (HW+1)'(t[i] - dvs);
					nxt.dq[i]   = {pipe_s[S].dq[i][DQ-2:0], 1'b1};
				end else begin
					nxt.drem[i] = t[i][HW:0];
					nxt.dq[i]   = {pipe_s[S].dq[i][DQ-2:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[S+1] <= 1'b0;
			end else if (adv) begin
				vld_s[S+1] <= vld_s[S];
			end
		end
		always_ff @(posedge clk) begin
			if (adv)
				pipe_s[S+1] <= nxt;
		end
	end

	// saturate and place components
	pipe_t         fin;
	logic [DW-1:0] rootc, qv [3];
	logic [DW-1:0] ox, oy, oz, ow;

	always_comb begin
		fin   = pipe_s[NST-1];
		rootc = sat_fn(1'b0, SW'(fin.h >> 1));
		for (int i = 0; i < 3; i++) begin
			if (fin.h == '0) begin
				qv[i] = fin.nzero[i] ? '0 : (fin.neg[i] ? MINO : MAXO);
			end else begin
				qv[i] = sat_fn(fin.neg[i], SW'(fin.dq[i]));
			end
		end
		case (fin.sel)
			BR_TRACE: begin ow = rootc; ox = qv[0]; oy = qv[1]; oz = qv[2]; end
			BR_X:     begin ox = rootc; ow = qv[0]; oy = qv[1]; oz = qv[2]; end
			BR_Y:     begin oy = rootc; ow = qv[0]; ox = qv[1]; oz = qv[2]; end
			default:  begin oz = rootc; ow = qv[0]; ox = qv[1]; oy = qv[2]; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s[NST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qx_q <= ox;
			qy_q <= oy;
			qz_q <= oz;
			qw_q <= ow;
			br_q <= fin.sel;
		end
	end

	assign quat.valid       = out_vld_q;
	assign quat.quat_x      = qx_q;
	assign quat.quat_y      = qy_q;
	assign quat.quat_z      = qz_q;
	assign quat.quat_w      = qw_q;
	assign quat.branch_case = br_q;

endmodule

// ===== design/b2q_checker.sv =====
// ----------------------------------------------------------------------------
// b2q_checker
// Port-level checks for basis_to_quaternion_core, bound into every instance of the core.
// ----------------------------------------------------------------------------
module b2q_checker import b2q_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  branch_case,
	input logic        qx_msb,
	input logic        qy_msb,
	input logic        qz_msb,
	input logic        qw_msb
);

	// stalled output request stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output request dropped while stalled");

	// stall at the output back-pressures the input
	a_stall_bp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	a_empty_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("not ready with empty output");

	// root component is never negative
	a_root_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((branch_case == BR_TRACE) && !qw_msb) ||
			((branch_case == BR_X) && !qx_msb) ||
			((branch_case == BR_Y) && !qy_msb) ||
			((branch_case == BR_Z) && !qz_msb))
		else $error("root component negative");

endmodule

bind basis_to_quaternion_core b2q_checker u_b2q_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (mat.ready),
	.out_valid   (quat.valid),
	.out_ready   (quat.ready),
	.branch_case (quat.branch_case),
	.qx_msb      (quat.quat_x[DATA_WIDTH-1]),
	.qy_msb      (quat.quat_y[DATA_WIDTH-1]),
	.qz_msb      (quat.quat_z[DATA_WIDTH-1]),
	.qw_msb      (quat.quat_w[DATA_WIDTH-1])
);
